[src/sdmc_pkg.sv]
// Package for the signed division magic-constant generator.
// Holds widths, phase codes, the search token type and the restoring step.
// No dependencies.
`default_nettype none
package sdmc_pkg;

   localparam int DW        = 32;
   localparam int QW        = 34;
   localparam int CELLS_DEF = 4;

   localparam logic [1:0] PH_MOD  = 2'd0;
   localparam logic [1:0] PH_ANC  = 2'd1;
   localparam logic [1:0] PH_SRCH = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [4:0]    CNT_LAST = 5'd31;
   localparam logic [5:0]    P_START  = 6'd31;
   localparam logic [5:0]    P_LIMIT  = 6'd63;
   localparam logic [5:0]    P_HALF   = 6'd32;
   localparam logic [DW-1:0] TWO_P31  = 32'h8000_0000;

   typedef struct packed {
      logic [DW-1:0] dvd;
      logic [DW-1:0] dvs;
      logic [DW-1:0] rem;
      logic [QW-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] phase;
      logic [4:0] cnt;
      logic [5:0] p;
      logic       neg;
      lane_type   a;
      lane_type   b;
   } tok_type;

   // one restoring division step: shift in the next dividend bit
   function automatic lane_type div_step(lane_type l);
      logic [DW:0] tmp;
      logic [DW:0] diff;
      logic        ge;
      lane_type    o;
      tmp   = {l.rem, l.dvd[DW-1]};
      diff  = tmp - {1'b0, l.dvs};
      ge    = (tmp >= {1'b0, l.dvs});
      o     = l;
      o.dvd = {l.dvd[DW-2:0], 1'b0};
      o.rem = ge ? diff[DW-1:0] : tmp[DW-1:0];
      o.quo = {l.quo[QW-2:0], ge};
      return o;
   endfunction

endpackage
`default_nettype wire

[src/sdmc_cell.sv]
// One search chain cell: a registered restoring step on both lanes (lane a only in PH_ANC, none in PH_DONE).
// Depends on sdmc_pkg.
`default_nettype none
module sdmc_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  sdmc_pkg::tok_type     tok_i,
   output sdmc_pkg::tok_type     tok_o
);
   import sdmc_pkg::*;

   tok_type       tok_ff;
   tok_type       tok_in;
   lane_type      a_s;
   lane_type      b_s;
   logic [DW-1:0] delta;
   logic [5:0]    p_nx;

   always_comb begin
      tok_in = tok_i;
      a_s    = div_step(tok_i.a);
      b_s    = div_step(tok_i.b);
      delta  = tok_i.b.dvs - b_s.rem;
      p_nx   = tok_i.p + 6'd1;
      unique case (tok_i.phase)
         PH_MOD: begin
            tok_in.a   = a_s;
            tok_in.b   = b_s;
            tok_in.cnt = tok_i.cnt + 5'd1;
            if (tok_i.cnt == CNT_LAST) begin
               tok_in.phase = PH_ANC;
               tok_in.a.dvd = TWO_P31;
               tok_in.a.dvs = TWO_P31 + {{(DW-1){1'b0}}, tok_i.neg} - 32'd1 - a_s.rem;
               tok_in.a.rem = '0;
               tok_in.a.quo = '0;
            end
         end
         PH_ANC: begin
            tok_in.a   = a_s;
            tok_in.cnt = tok_i.cnt + 5'd1;
            if (tok_i.cnt == CNT_LAST) begin
               tok_in.phase = PH_SRCH;
            end
         end
         PH_SRCH: begin
            tok_in.a = a_s;
            tok_in.b = b_s;
            tok_in.p = p_nx;
            if ((a_s.quo > {2'b00, delta}) ||
                ((a_s.quo == {2'b00, delta}) && (a_s.rem != '0)) ||
                (p_nx >= P_LIMIT)) begin
               tok_in.phase = PH_DONE;
            end
         end
         default: begin
            tok_in = tok_i;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

[src/signed_div_magic_constant_gen.sv]
// Top level of the signed 32-bit division magic-constant generator.
// Depends on sdmc_pkg and sdmc_cell.
//
//   channel | dir | tdata fields (lsb first)
//   req     | in  | divisor[31:0]
//   rsp     | out | magic[32:0], post_shift[37:33], need_add[38], div_by_zero[39]
//
// Zero, +1, -1 and positive powers of two skip the ring: the result goes to res_ff, then to the output register.
// Other divisors: 64 steps (remainder pass, anc division) plus 1 to 32 search steps, one
// step per cycle as the token moves on around a ring of CELLS cells; the result is taken
// when the token reaches the last cell.
// req_tready is low until the result moves to the output register; rsp stalls add to that.
// Synchronous active-high reset clears the ring and the handshake state.
`default_nettype none
module signed_div_magic_constant_gen #(
   parameter int CELLS = sdmc_pkg::CELLS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // divisor[31:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // magic, post_shift, need_add, div_by_zero
);
   import sdmc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   tok_type       chain [0:CELLS];
   tok_type       tail;
   logic [1:0]    state_ff, state_in;
   logic [39:0]   res_ff, res_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [39:0]   rsp_tdata_ff, rsp_tdata_in;

   logic [DW-1:0] d;
   logic [DW-1:0] ad;
   logic          is_zero, is_one, is_m1, is_pow2;
   logic [4:0]    lg2;
   logic [QW-1:0] mag;
   logic [5:0]    sh;
   tok_type       inj;

   genvar gi;
   generate
      for (gi = 0; gi < CELLS; gi++) begin : g_cell
         sdmc_cell u_cell (
            .clock (clock),
            .reset (reset),
            .tok_i (chain[gi]),
            .tok_o (chain[gi+1])
         );
      end
   endgenerate

   assign tail = chain[CELLS];

   always_comb begin
      d       = req_tdata;
      ad      = d[DW-1] ? (32'd0 - d) : d;
      is_zero = (d == 32'd0);
      is_one  = (d == 32'd1);
      is_m1   = (d == 32'hFFFF_FFFF);
      is_pow2 = !d[DW-1] && !is_zero && ((d & (d - 32'd1)) == 32'd0);
      lg2     = '0;
      for (int i = 0; i < DW; i++) begin
         lg2 = lg2 | (d[i] ? 5'(i) : 5'd0);
      end
      mag = tail.b.quo + {{(QW-1){1'b0}}, 1'b1};
      sh  = tail.p - P_HALF;

      inj       = '0;
      inj.valid = 1'b1;
      inj.phase = PH_MOD;
      inj.p     = P_START;
      inj.neg   = d[DW-1];
      inj.a.dvd = TWO_P31 | {{(DW-1){1'b0}}, d[DW-1]};
      inj.a.dvs = ad;
      inj.b.dvd = TWO_P31;
      inj.b.dvs = ad;
   end

   always_comb begin
      state_in      = state_ff;
      res_in        = res_ff;
      req_tready    = (state_ff == ST_IDLE);
      chain[0]      = tail;
      chain[0].valid = tail.valid && (tail.phase != PH_DONE);
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (is_zero) begin
                  res_in   = {1'b1, 39'd0};
                  state_in = ST_HOLD;
               end else if (is_one) begin
                  res_in   = {2'b00, 5'd0, 33'd1};
                  state_in = ST_HOLD;
               end else if (is_m1) begin
                  res_in   = {2'b00, 5'd0, {33{1'b1}}};
                  state_in = ST_HOLD;
               end else if (is_pow2) begin
                  res_in   = {2'b00, lg2, 33'd1};
                  state_in = ST_HOLD;
               end else begin
                  chain[0] = inj;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (tail.valid && (tail.phase == PH_DONE)) begin
               res_in   = {1'b0, (mag[32] | mag[31]), sh[4:0], mag[32:0]};
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff       <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

[src/sdmc_chk.sv]
// Port-level checker for the magic-constant generator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module sdmc_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer changed while stalled");

   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |-> (rsp_tdata[38:0] == 39'd0))
      else $error("zero divisor result has nonzero fields");

   a_add: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38] |-> !rsp_tdata[32] && rsp_tdata[31] && !rsp_tdata[39])
      else $error("add flag inconsistent with magic");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("req transfer changed while stalled");

endmodule

bind signed_div_magic_constant_gen sdmc_chk u_sdmc_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
